@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ale_pkg.sv @@
// ----------------------------------------------------------------------------
// ale_pkg
// Defaults and request / status codes of the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [2:0] MODE_SEARCH = 3'd0;
  localparam logic [2:0] MODE_APPEND = 3'd1;
  localparam logic [2:0] MODE_INSERT = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

endpackage

@@ hw/rtl/array_list_engine.sv @@
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of signed words with search, append, insert, delete and read.
// ----------------------------------------------------------------------------
// Usage: drive mode, value and position with start high; the word is taken
// at a rising edge where start is high and busy is low. Exactly one result
// follows, shown for one cycle with done high: status, found_index,
// read_value and entry_count. The receiver cannot stall it.
// Append, failed checks and unknown modes complete straight from idle. A
// read waits on the entry memory, then returns the word. Search walks from
// index zero to the match; delete walks to the match, then shifts every
// later entry down; insert at p shifts the entries from p to the end up,
// starting at the end, then writes the word. The entry memory has registered
// read data, so every step of a walk is an entry read, then a compare or write.
// One request is in flight at a time; busy stays high until its result.
// Reset empties the list (count zero); stored entries are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module array_list_engine #(
  parameter int DEPTH      = ale_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ale_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic signed [31:0] value,
  input  logic [6:0]         position,
  output logic               done,
  output logic [1:0]         status,
  output logic [6:0]         found_index,
  output logic signed [31:0] read_value,
  output logic [7:0]         entry_count
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CPW = (CW > 7) ? CW : 7;

  typedef enum logic [3:0] {
    IDLE, SCAN_RD, SCAN_CMP, DN_RD, DN_WR, UP_RD, UP_WR, INS_WR, RD_WAIT, RD_OUT
  } state_t;

  state_t                state;
  logic [2:0]            op;
  logic [DATA_WIDTH-1:0] word;
  logic [AW-1:0]         pidx;
  logic [AW-1:0]         ptr;
  logic [CW-1:0]         cnt;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic                  accept;
  logic [DATA_WIDTH-1:0] in_word;
  logic signed [63:0]    in_ext;
  logic signed [63:0]    rd_ext;
  logic                  full;
  logic [CPW-1:0]        pos_w;
  logic [CPW-1:0]        cnt_w;
  logic [CW-1:0]         ptr1;
  logic [CW-1:0]         ptr2;
  logic [AW-1:0]         ptr_dec;
  logic [AW-1:0]         pos_a;
  logic [1:0]            status_in;
  state_t                state_in;
  logic                  grow;

  assign accept  = start && !busy;
  assign busy    = (state != IDLE);
  assign in_ext  = 64'(value);
  assign in_word = in_ext[DATA_WIDTH-1:0];
  assign rd_ext  = 64'($signed(rdata));
  assign full    = (cnt == CW'(DEPTH));
  assign pos_w   = CPW'(position);
  assign cnt_w   = CPW'(cnt);
  assign pos_a   = AW'(position);
  assign ptr1    = CW'(ptr) + CW'(1);
  assign ptr2    = ptr1 + CW'(1);
  assign ptr_dec = ptr - AW'(1);
  assign entry_count = 8'(cnt);

  ale_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    status_in = ale_pkg::ST_OK;
    state_in  = IDLE;
    grow      = 1'b0;
    unique case (mode)
      ale_pkg::MODE_SEARCH, ale_pkg::MODE_DELETE: begin
        if (cnt == '0) begin
          status_in = ale_pkg::ST_NOTFOUND;
        end else begin
          state_in = SCAN_RD;
        end
      end
      ale_pkg::MODE_APPEND: begin
        if (full) begin
          status_in = ale_pkg::ST_FULL;
        end else begin
          grow = 1'b1;
        end
      end
      ale_pkg::MODE_INSERT: begin
        if (full) begin
          status_in = ale_pkg::ST_FULL;
        end else if (pos_w > cnt_w) begin
          status_in = ale_pkg::ST_RANGE;
        end else if (pos_w == cnt_w) begin
          grow = 1'b1;
        end else begin
          state_in = UP_RD;
        end
      end
      ale_pkg::MODE_READ: begin
        if (pos_w >= cnt_w) begin
          status_in = ale_pkg::ST_RANGE;
        end else begin
          state_in = RD_WAIT;
        end
      end
      default: grow = 1'b0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = rdata;
    raddr = ptr;
    unique case (state)
      IDLE: begin
        waddr = cnt[AW-1:0];
        wdata = in_word;
        we    = accept && grow;
      end
      SCAN_RD: raddr = ptr;
      SCAN_CMP: raddr = ptr;
      DN_RD: raddr = ptr1[AW-1:0];
      DN_WR: we = 1'b1;
      UP_RD: raddr = ptr_dec;
      UP_WR: we = 1'b1;
      INS_WR: begin
        we    = 1'b1;
        waddr = pidx;
        wdata = word;
      end
      RD_WAIT: raddr = pidx;
      RD_OUT: raddr = pidx;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          done <= accept && (state_in == IDLE);
          if (accept) begin
            op          <= mode;
            word        <= in_word;
            pidx        <= pos_a;
            ptr         <= (mode == ale_pkg::MODE_INSERT) ? cnt[AW-1:0] : '0;
            status      <= status_in;
            found_index <= '0;
            read_value  <= '0;
            state       <= state_in;
            if (grow) begin
              cnt <= cnt + CW'(1);
            end
          end
        end
        SCAN_RD: begin
          done  <= 1'b0;
          state <= SCAN_CMP;
        end
        SCAN_CMP: begin
          if (rdata == word) begin
            found_index <= 7'(ptr);
            if (op == ale_pkg::MODE_SEARCH) begin
              done  <= 1'b1;
              state <= IDLE;
            end else if (ptr1 < cnt) begin
              done  <= 1'b0;
              state <= DN_RD;
            end else begin
              cnt   <= cnt - CW'(1);
              done  <= 1'b1;
              state <= IDLE;
            end
          end else if (ptr1 >= cnt) begin
            status <= ale_pkg::ST_NOTFOUND;
            done   <= 1'b1;
            state  <= IDLE;
          end else begin
            ptr   <= ptr1[AW-1:0];
            done  <= 1'b0;
            state <= SCAN_RD;
          end
        end
        DN_RD: begin
          done  <= 1'b0;
          state <= DN_WR;
        end
        DN_WR: begin
          if (ptr2 < cnt) begin
            ptr   <= ptr1[AW-1:0];
            done  <= 1'b0;
            state <= DN_RD;
          end else begin
            cnt   <= cnt - CW'(1);
            done  <= 1'b1;
            state <= IDLE;
          end
        end
        UP_RD: begin
          done  <= 1'b0;
          state <= UP_WR;
        end
        UP_WR: begin
          done <= 1'b0;
          ptr  <= ptr_dec;
          if (ptr_dec == pidx) begin
            state <= INS_WR;
          end else begin
            state <= UP_RD;
          end
        end
        INS_WR: begin
          cnt   <= cnt + CW'(1);
          done  <= 1'b1;
          state <= IDLE;
        end
        RD_WAIT: begin
          done  <= 1'b0;
          state <= RD_OUT;
        end
        RD_OUT: begin
          read_value <= rd_ext[31:0];
          done       <= 1'b1;
          state      <= IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= IDLE;
        end
      endcase
    end
  end

  `CHK_NOW(a_cnt_bound, 1'b1, cnt <= CW'(DEPTH), "entry count above depth")
  `CHK_NEXT(a_accept_progress, accept, busy || done, "accepted word left no trace")
  `CHK_NOW(a_fail_keeps_cnt, done && status != ale_pkg::ST_OK, $stable(cnt),
    "failed request changed the count")
  `CHK_NOW(a_write_in_list, we, CW'(waddr) <= cnt, "write beyond list end")

endmodule

@@ hw/rtl/ale_ram.sv @@
// ----------------------------------------------------------------------------
// ale_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ale_ram #(
  parameter int DEPTH      = ale_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ale_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [DATA_WIDTH-1:0]         rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
